// ----- sv/piecewise_linear_curve_eval_defines.svh -----
// Assertion macros used by the curve evaluator back end
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PLCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PLCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/plce_pkg.sv -----
// Types and constants of the piecewise-linear curve evaluator
package plce_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int CNT_W  = 5;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_EMPTY = 1'b1;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SKIP  = 2'd1;
	localparam logic [1:0] OP_EMPTY = 2'd2;
	localparam logic [1:0] OP_EVAL  = 2'd3;

	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = 1;
	localparam int Q_CW    = 2;

	localparam int DIV_STEPS = 32;
	localparam int DSW       = 5;

	typedef struct packed {
		logic [1:0]              op;
		logic [IDX_W-1:0]        idx;
		logic signed [DATA_W-1:0] a;   // point x, or curve input
		logic signed [DATA_W-1:0] b;   // point y
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] mag;  // |y1 - y0|
		logic [DATA_W-1:0] dv;   // v - x0
		logic [DATA_W-1:0] dx;   // x1 - x0
	} div_req_t;

endpackage

// ----- sv/plce_if.sv -----
// Request and response channel interfaces of the curve evaluator
interface plce_req_if;
	import plce_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [IDX_W-1:0]         point_index;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;
	logic signed [DATA_W-1:0] var_value;

	modport source (output valid, req_type, point_index, point_x, point_y, var_value,
		input ready);
	modport sink (input valid, req_type, point_index, point_x, point_y, var_value,
		output ready);
endinterface

interface plce_rsp_if;
	import plce_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] curve_result;
	logic                     status;

	modport source (output valid, curve_result, status, input ready);
	modport sink (input valid, curve_result, status, output ready);
endinterface

// ----- sv/plce_front.sv -----
// Front end: takes request beats and classifies them into queue commands
module plce_front #(
	parameter int MAX_POINTS = 16
) (
	plce_req_if.sink                 req,
	input  logic [plce_pkg::CNT_W-1:0] point_count,
	input  logic                     full,
	output logic                     push,
	output plce_pkg::cmd_t           cmd
);
	import plce_pkg::*;

	logic idx_ok;

	assign idx_ok    = int'(req.point_index) < MAX_POINTS;
	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		cmd.idx = req.point_index;
		cmd.b   = req.point_y;
		if (req.req_type == REQ_LOAD) begin
			cmd.op = idx_ok ? OP_LOAD : OP_SKIP;
			cmd.a  = req.point_x;
		end else begin
			// a zero count stays zero after clamping, so test it raw
			cmd.op = (point_count == '0) ? OP_EMPTY : OP_EVAL;
			cmd.a  = req.var_value;
		end
	end

endmodule

// ----- sv/plce_queue.sv -----
// Two-entry command queue between the front end and the evaluation engine
module plce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  plce_pkg::cmd_t wdata,
	output logic           full,
	output logic           valid,
	output plce_pkg::cmd_t rdata,
	input  logic           pop
);
	import plce_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_PW-1:0] wr_ptr_q;
	logic [Q_PW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign full  = cnt_q == Q_CW'(Q_DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- sv/plce_div.sv -----
// Interpolation unit: one 32x32 multiply, then a bit-serial 64/32 divide
module plce_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  plce_pkg::div_req_t         req,
	output logic                       busy,
	output logic                       done,
	output logic [plce_pkg::DATA_W-1:0] quo
);
	import plce_pkg::*;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_MUL  = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;

	logic [1:0]        state_q;
	logic [DSW-1:0]    cnt_q;
	logic              done_q;
	logic [DATA_W-1:0] mag_q;
	logic [DATA_W-1:0] dv_q;
	logic [DATA_W-1:0] dx_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] lo_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;
	logic              ge;

	assign busy = state_q != D_IDLE;
	assign done = done_q;
	assign quo  = lo_q;

	// the quotient is known to fit 32 bits, so the high product half is already
	// below the divisor and only the low half needs stepping through
	assign shifted = {rem_q, lo_q[DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dx_q};
	assign ge      = !diff[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					cnt_q   <= '0;
					state_q <= D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q + DSW'(1);
					if (cnt_q == DSW'(DIV_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			mag_q <= req.mag;
			dv_q  <= req.dv;
			dx_q  <= req.dx;
		end
		if (state_q == D_MUL) begin
			{rem_q, lo_q} <= (2*DATA_W)'(mag_q) * (2*DATA_W)'(dv_q);
		end else if (state_q == D_RUN) begin
			rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			lo_q  <= {lo_q[DATA_W-2:0], ge};
		end
	end

endmodule

// ----- sv/plce_back.sv -----
// Evaluation engine: point table, segment search, interpolation and result register
`include "piecewise_linear_curve_eval_defines.svh"

module plce_back #(
	parameter int MAX_POINTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [plce_pkg::CNT_W-1:0] point_count,
	input  logic                       cmd_valid,
	input  plce_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	plce_rsp_if.source                 rsp
);
	import plce_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int EW = (CW > CNT_W) ? CW : CNT_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LAST  = 3'd1;
	localparam logic [2:0] S_FIRST = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
	logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
	logic signed [DATA_W-1:0] rd_x_q;
	logic signed [DATA_W-1:0] rd_y_q;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;

	logic [2:0]               state_q;
	logic [2:0]               state_d;
	logic signed [DATA_W-1:0] v_q;
	logic [AW-1:0]            last_idx_q;
	logic [AW-1:0]            cur_idx_q;
	logic signed [DATA_W-1:0] last_x_q;
	logic signed [DATA_W-1:0] last_y_q;
	logic signed [DATA_W-1:0] prev_x_q;
	logic signed [DATA_W-1:0] prev_y_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     stat_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_result_q;
	logic                     out_status_q;
	logic                     out_load;

	logic [EW-1:0]            pc_ext;
	logic [CW-1:0]            n_cnt;
	logic [AW-1:0]            last_idx;
	logic                     bracket;
	logic signed [DATA_W:0]   dx;
	logic signed [DATA_W:0]   dv;
	logic signed [DATA_W:0]   dy;
	logic [DATA_W:0]          dy_neg;
	logic                     dx_zero;
	logic signed [DATA_W+1:0] sum;
	logic signed [DATA_W-1:0] sum_sat;

	div_req_t                 div_req;
	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [DATA_W-1:0]        div_quo;

	plce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// clamp the count to the table size
	assign pc_ext   = EW'(point_count);
	assign n_cnt    = (pc_ext > EW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pc_ext);
	assign last_idx = AW'(n_cnt - CW'(1));

	// segment from the held point to the entry just read
	assign bracket = (v_q >= prev_x_q) && (v_q <= rd_x_q);
	assign dx      = {rd_x_q[DATA_W-1], rd_x_q} - {prev_x_q[DATA_W-1], prev_x_q};
	assign dv      = {v_q[DATA_W-1], v_q} - {prev_x_q[DATA_W-1], prev_x_q};
	assign dy      = {rd_y_q[DATA_W-1], rd_y_q} - {prev_y_q[DATA_W-1], prev_y_q};
	assign dy_neg  = -dy;
	assign dx_zero = dx == '0;

	assign div_req.mag = dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
	assign div_req.dv  = dv[DATA_W-1:0];
	assign div_req.dx  = dx[DATA_W-1:0];

	// apply the sign of the rise and saturate to 32 bits
	always_comb begin
		if (neg_q) begin
			sum = (DATA_W+2)'(prev_y_q) - $signed({2'b00, div_quo});
		end else begin
			sum = (DATA_W+2)'(prev_y_q) + $signed({2'b00, div_quo});
		end
		if (!sum[DATA_W+1] && sum[DATA_W:DATA_W-1] != 2'b00) begin
			sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sum[DATA_W+1] && sum[DATA_W:DATA_W-1] != 2'b11) begin
			sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sum_sat = sum[DATA_W-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		rd_addr   = cur_idx_q + AW'(1);
		case (state_q)
			S_IDLE: begin
				rd_addr = last_idx;
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					wr_en   = cmd.op == OP_LOAD;
					state_d = (cmd.op == OP_EVAL) ? S_LAST : S_OUT;
				end
			end
			S_LAST: begin
				rd_addr = '0;
				state_d = S_FIRST;
			end
			S_FIRST: begin
				rd_addr = AW'(1);
				if (v_q <= rd_x_q || v_q >= last_x_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (bracket && !dx_zero) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else if (bracket || cur_idx_q == last_idx_q) begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_mem[AW'(cmd.idx)] <= cmd.a;
			y_mem[AW'(cmd.idx)] <= cmd.b;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_q      <= '0;
				stat_q     <= (cmd.op == OP_EMPTY) ? ST_EMPTY : ST_OK;
				v_q        <= cmd.a;
				last_idx_q <= last_idx;
			end
			S_LAST: begin
				last_x_q <= rd_x_q;
				last_y_q <= rd_y_q;
			end
			S_FIRST: begin
				res_q     <= (v_q <= rd_x_q) ? rd_y_q : last_y_q;
				prev_x_q  <= rd_x_q;
				prev_y_q  <= rd_y_q;
				cur_idx_q <= AW'(1);
			end
			S_SCAN: begin
				// hold the segment start while the divide runs
				if (bracket) begin
					res_q <= prev_y_q;
					neg_q <= dy[DATA_W];
				end else if (cur_idx_q == last_idx_q) begin
					res_q <= prev_y_q;
				end else begin
					prev_x_q  <= rd_x_q;
					prev_y_q  <= rd_y_q;
					cur_idx_q <= cur_idx_q + AW'(1);
				end
			end
			S_DIV: begin
				if (div_done) begin
					res_q <= sum_sat;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_result_q <= res_q;
			out_status_q <= stat_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.curve_result = out_result_q;
	assign rsp.status       = out_status_q;

	`PLCE_ASSERT_IMP(a_empty_zero, out_valid_q && out_status_q == ST_EMPTY, out_result_q == '0, "empty-table beat carries a nonzero result")
	`PLCE_ASSERT_IMP(a_done_in_div, div_done, state_q == S_DIV, "divider finished while engine not waiting")
	`PLCE_ASSERT_NXT(a_start_busy, div_start, state_q == S_DIV && div_busy, "divider did not take the start")
	`PLCE_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, cur_idx_q <= last_idx_q, "segment search ran past the last point")

endmodule

// ----- sv/piecewise_linear_curve_eval.sv -----
// Piecewise-linear curve evaluator: top level
//
// Request channel (req): each beat is either a load (req_type 0) that writes
// point_x/point_y into table entry point_index, or an evaluation (req_type 1)
// of the curve at var_value. Every request beat gives exactly one response
// beat on rsp, in order: curve_result and status (1 for an evaluation with
// an empty table). Loads answer with zero. point_count must be written through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// Steps per evaluation: the engine reads the last and the first table entry and
// goes straight to the response for a value clamped to an end point; else it
// searches the table, one table entry per cycle, and a segment of nonzero width
// is then interpolated by the divider: a multiply, then one quotient bit per
// cycle, 32 bits in all. Loads and empty-table evaluations go straight to the
// response register.
// Items are worked one at a time, a new one after the last is registered; a
// two-entry queue in front keeps req ready while an item is in work, until it
// fills; the response register holds a beat while rsp stalls, holding the engine.
// Reset clears point_count, the queue and the response valid; table contents
// are undefined until loaded and need no clearing.
module piecewise_linear_curve_eval #(
	parameter int MAX_POINTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	plce_req_if.sink                   req,
	plce_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [plce_pkg::CNT_W-1:0] cfg_wdata
);
	import plce_pkg::*;

	logic [CNT_W-1:0] point_count_q;
	logic             q_push;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;
	cmd_t             q_wdata;
	cmd_t             q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	plce_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.req         (req),
		.point_count (point_count_q),
		.full        (q_full),
		.push        (q_push),
		.cmd         (q_wdata)
	);

	plce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	plce_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (point_count_q),
		.cmd_valid   (q_valid),
		.cmd         (q_rdata),
		.cmd_pop     (q_pop),
		.rsp         (rsp)
	);

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the piecewise-linear curve evaluator: point loads, curve evaluations, checking
module tb_top;
	import plce_pkg::*;

	localparam int RANDOM_ITEMS    = 1100;
	localparam int CALM_ITEMS      = 150;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int SETTLE_CYCLES   = 60;
	localparam int TABLE_SIZE      = 16;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	plce_req_if req ();
	plce_rsp_if rsp ();

	piecewise_linear_curve_eval dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     status;
	} curve_beat_t;

	class curve_checker;
		logic signed [DATA_W-1:0] x_pts[TABLE_SIZE];
		logic signed [DATA_W-1:0] y_pts[TABLE_SIZE];
		logic [CNT_W-1:0]         count = '0;
		curve_beat_t              awaited[$];
		int                       mismatches = 0;

		function void eval_curve(input logic signed [DATA_W-1:0] v,
				output logic signed [DATA_W-1:0] res, output logic st);
			int          n;
			longint      x0, x1, y0, dy, acc;
			logic [63:0] mag, dv, dx, q;
			n = (count > 5'd16) ? TABLE_SIZE : int'(count);
			res = '0;
			st = ST_OK;
			if (n == 0) begin
				st = ST_EMPTY;
				return;
			end
			if (v <= x_pts[0]) begin
				res = y_pts[0];
			end else if (v >= x_pts[n-1]) begin
				res = y_pts[n-1];
			end else begin
				for (int i = 0; i + 1 < n; i++) begin
					res = y_pts[i];
					if (v >= x_pts[i] && v <= x_pts[i+1]) begin
						x0 = longint'(x_pts[i]);
						x1 = longint'(x_pts[i+1]);
						y0 = longint'(y_pts[i]);
						dy = longint'(y_pts[i+1]) - y0;
						dx = x1 - x0;
						dv = longint'(v) - x0;
						if (dx != 0) begin
							// exact product first, then truncate toward zero
							mag = (dy < 0) ? -dy : dy;
							q = (mag * dv) / dx;
							acc = (dy < 0) ? y0 - $signed(q) : y0 + $signed(q);
							if (acc > 64'sd2147483647)
								acc = 64'sd2147483647;
							if (acc < -64'sd2147483648)
								acc = -64'sd2147483648;
							res = acc[DATA_W-1:0];
						end
						break;
					end
				end
			end
		endfunction

		function void note_input(logic kind, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
				logic signed [DATA_W-1:0] val);
			curve_beat_t b;
			if (kind == REQ_LOAD) begin
				x_pts[idx] = px;
				y_pts[idx] = py;
				b.value = '0;
				b.status = ST_OK;
			end else begin
				eval_curve(val, b.value, b.status);
			end
			awaited.push_back(b);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] got, logic st);
			curve_beat_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response beat with nothing outstanding: %h/%0d",
						$time, got, st);
				return;
			end
			e = awaited.pop_front();
			if (got !== e.value || st !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected result %h status %0d, got %h status %0d",
						$time, e.value, e.status, got, st);
			end
		endfunction
	endclass

	curve_checker sb;
	bit           calm;
	int           items_sent;
	int           stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// score both channels on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.curve_result, rsp.status);
			if (req.valid && req.ready)
				sb.note_input(req.req_type, req.point_index, req.point_x, req.point_y,
					req.var_value);
		end
	end

	// response back-pressure in short bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && arst_n && $urandom_range(0, 4) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("piecewise_linear_curve_eval verification failed");
		$finish;
	end

	task automatic send_item(logic kind, logic [IDX_W-1:0] idx,
			logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
			logic signed [DATA_W-1:0] val);
		int gap;
		@(negedge clk);
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.req_type    <= kind;
		req.point_index <= idx;
		req.point_x     <= px;
		req.point_y     <= py;
		req.var_value   <= val;
		req.valid       <= 1'b1;
		do
			@(posedge clk);
		while (!req.ready);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.awaited.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] c);
		drain_results();
		cfg_wdata <= c;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.count = c;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_input();
		int                n, r, k;
		longint            lo, hi;
		logic [63:0]       span, r64;
		logic signed [63:0] pick;
		n = (sb.count > 5'd16) ? TABLE_SIZE : int'(sb.count);
		r = $urandom_range(0, 99);
		if (n == 0 || r >= 85)
			return $urandom;
		lo = longint'(sb.x_pts[0]);
		hi = longint'(sb.x_pts[n-1]);
		if (r < 55 && hi > lo) begin
			span = hi - lo + 1;
			r64 = {$urandom, $urandom};
			pick = lo + (r64 % span);
		end else if (r < 75) begin
			// land on a point or just either side of it
			k = $urandom_range(0, n - 1);
			pick = longint'(sb.x_pts[k]) + $urandom_range(0, 2) - 1;
		end else if (r < 80) begin
			pick = lo - $urandom_range(0, 65536);
		end else begin
			pick = hi + $urandom_range(0, 65536);
		end
		return pick[DATA_W-1:0];
	endfunction

	task automatic run_sorted_phase();
		int xq[$];
		int yv[TABLE_SIZE];
		int order[TABLE_SIZE];
		int tmp, j, base;
		bit narrow_x, narrow_y;
		narrow_x = 1'($urandom_range(0, 1));
		narrow_y = 1'($urandom_range(0, 1));
		base = int'($urandom_range(0, 2097152)) - 1048576;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (narrow_x) begin
				// skip the step now and then to get repeated x
				if (i > 0 && $urandom_range(0, 3) != 0)
					base += $urandom_range(1, 262144);
				xq.push_back(base);
			end else begin
				xq.push_back(int'($urandom));
			end
			yv[i] = narrow_y ? int'($urandom_range(0, 1048576)) - 524288 : int'($urandom);
			order[i] = i;
		end
		xq.sort();
		for (int i = TABLE_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < TABLE_SIZE; i++)
			send_item(REQ_LOAD, IDX_W'(order[i]), xq[order[i]], yv[order[i]], $urandom);
		repeat ($urandom_range(40, 80)) begin
			if (!calm && $urandom_range(0, 49) == 0)
				drain_results();
			send_item(REQ_EVAL, IDX_W'($urandom_range(0, 15)), $urandom, $urandom,
				pick_input());
		end
	endtask

	task automatic run_noise_phase();
		repeat ($urandom_range(30, 50)) begin
			if ($urandom_range(0, 9) < 4)
				send_item(REQ_LOAD, IDX_W'($urandom_range(0, 15)), $urandom, $urandom,
					$urandom);
			else
				send_item(REQ_EVAL, IDX_W'($urandom_range(0, 15)), $urandom, $urandom,
					pick_input());
		end
	endtask

	initial begin
		logic signed [DATA_W-1:0] dx_pts[TABLE_SIZE];
		logic signed [DATA_W-1:0] dy_pts[TABLE_SIZE];
		int                       start;
		int                       pick;
		sb = new;
		calm = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_LOAD;
		req.point_index = '0;
		req.point_x = '0;
		req.point_y = '0;
		req.var_value = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table
		send_item(REQ_EVAL, 4'hf, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_item(REQ_EVAL, 4'h0, 32'h80000000, 32'h7fffffff, 32'h80000000);

		// full-range ascending table with alternating extreme y and one repeated x
		for (int i = 0; i < TABLE_SIZE; i++) begin
			dx_pts[i] = 32'h80000000 + i * 32'h10000000;
			dy_pts[i] = i[0] ? 32'h7fffffff : 32'h80000000;
		end
		dx_pts[TABLE_SIZE-1] = 32'h7fffffff;
		dx_pts[4] = dx_pts[3];
		for (int i = 0; i < TABLE_SIZE; i++)
			send_item(REQ_LOAD, IDX_W'(i), dx_pts[i], dy_pts[i], $urandom);

		write_count(5'd16);
		send_item(REQ_EVAL, 4'h5, 32'h0, 32'h0, 32'h80000000);
		send_item(REQ_EVAL, 4'ha, 32'hffffffff, 32'hffffffff, 32'h7fffffff);
		send_item(REQ_EVAL, 4'h3, 32'h0, 32'h0, dx_pts[3]);
		send_item(REQ_EVAL, 4'h7, 32'h0, 32'h0, 32'h08000000);
		send_item(REQ_EVAL, 4'h1, 32'h0, 32'h0, dx_pts[7] + 1);

		// count beyond the table size
		write_count(5'd31);
		send_item(REQ_EVAL, 4'h2, 32'h0, 32'h0, 32'h75000000);
		send_item(REQ_EVAL, 4'h2, 32'h0, 32'h0, 32'h7fffffff);

		write_count(5'd1);
		send_item(REQ_EVAL, 4'h9, 32'h0, 32'h0, 32'h0);
		write_count(5'd2);
		send_item(REQ_EVAL, 4'h6, 32'h0, 32'h0, 32'h88000000);

		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			calm = (items_sent - start >= RANDOM_ITEMS - CALM_ITEMS);
			pick = $urandom_range(0, 9);
			case (pick)
				0: write_count(5'd0);
				1: write_count(5'd1);
				2: write_count(5'd16);
				3: write_count(5'd2);
				default: write_count(CNT_W'($urandom_range(3, 16)));
			endcase
			if ($urandom_range(0, 9) < 7)
				run_sorted_phase();
			else
				run_noise_phase();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("piecewise_linear_curve_eval verification clean");
		else
			$display("piecewise_linear_curve_eval verification failed");
		$finish;
	end

endmodule

// ----- piecewise_linear_curve_eval.f -----
+incdir+sv
sv/plce_pkg.sv
sv/plce_if.sv
sv/plce_front.sv
sv/plce_queue.sv
sv/plce_div.sv
sv/plce_back.sv
sv/piecewise_linear_curve_eval.sv
bench/tb_top.sv
